@@ src/maq_pkg.sv @@
// ----------------------------------------------------------------------------
// maq_pkg
// Shared types and constants of the multiplexed alarm queue.
// ----------------------------------------------------------------------------
package maq_pkg;

  localparam int unsigned NumSlotsDefault = 16;
  localparam int unsigned MaxResults      = 16;
  localparam logic [31:0] RateReset       = 32'd32768;
  localparam logic [31:0] MsPerSec        = 32'd1000;
  // ceil(2^38 / 1000): multiply, then shift right by 38, divides any 32-bit
  // value by 1000 exactly
  localparam logic [31:0] Recip1000       = 32'd274877907;
  localparam int unsigned RecipShift      = 38;

  typedef enum logic [1:0] {
    MODE_ARM_ABS = 2'd0,
    MODE_ARM_REP = 2'd1,
    MODE_CANCEL  = 2'd2,
    MODE_TICK    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_ACK   = 2'd0,
    KIND_FIRED = 2'd1,
    KIND_IDLE  = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CONV,
    ST_WRITE,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_EMIT,
    ST_UPDATE,
    ST_NEXT,
    ST_NEXT_LAST,
    ST_OUT
  } state_t;

endpackage

@@ src/multiplexed_alarm_queue.sv @@
// ----------------------------------------------------------------------------
// multiplexed_alarm_queue
// Many alarm slots multiplexed onto one 32-bit counter compare.
// ----------------------------------------------------------------------------
// channel   direction  fields (tdata low bit up)
// s_axis    in         mode[1:0] slot[5:2] now[37:6] expiry[69:38] period_ms[101:70]
// m_axis    out        kind[1:0] fired_slot[5:2] fire_time[37:6] fired_expiry[69:38]
//                      next_valid[70] next_compare[102:71]; tlast = last
// cfg       in         tick_rate_hz written when cfg_we is high
//
// An arm or cancel writes the slot, then walks every slot to find the next compare;
// a repeating arm first converts milliseconds to ticks (reciprocal multiply).
// A tick scans all slots repeatedly, one fired alarm per scan, then walks them for the
// next compare; results then go out one per cycle while the receiver takes them. Every
// pass walks the slot memory one entry per cycle through its single read port.
// Reset clears the state machine and the active bits and sets the rate register to its default.
// Input is refused until the final result of the current item is taken.
module multiplexed_alarm_queue #(
  parameter int unsigned NUM_SLOTS = maq_pkg::NumSlotsDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [31:0]  cfg_wdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,  // mode, slot, now, expiry, period_ms, zero pad
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,  // kind, fired_slot, fire_time, fired_expiry,
                                      // next_valid, next_compare, zero pad
  output logic         m_axis_tlast
);
  localparam int unsigned SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CW = $clog2(NUM_SLOTS + 1);

  logic [31:0] tick_rate_hz;

  // slot memory: {repeat, reference, expiry, period}
  logic [96:0] mem [NUM_SLOTS];
  logic [96:0] rd_data;
  logic [SW-1:0] rd_addr;
  logic          we;
  logic [SW-1:0] wr_addr;
  logic [96:0]   wr_data;
  logic [NUM_SLOTS-1:0] active, done_mask;

  // forward a same-cycle write so a scan started right after it sees the new entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= (we && wr_addr == rd_addr) ? wr_data : mem[rd_addr];
  end

  maq_pkg::state_t state, state_next;
  logic [1:0]  mode;
  logic [3:0]  slot_in;
  logic [31:0] now, expiry_in, ms;
  logic [CW-1:0] cnt;           // scan index
  logic [SW-1:0] addr_q;        // address of the entry now in rd_data
  logic [4:0]  nfired;
  // millisecond conversion
  logic [31:0] quo, rem, rate_k;
  logic [1:0]  dcnt;
  logic [31:0] iv;
  // scan results
  logic          best_found;
  logic [31:0]   best_val, best_exp;
  logic [SW-1:0] best_slot;
  logic          best_rep;
  logic [31:0]   best_per;
  // fired alarms of the current tick, emitted after the final scan
  logic [3:0]  fire_slot [maq_pkg::MaxResults];
  logic [31:0] fire_exp  [maq_pkg::MaxResults];
  logic [3:0]  eidx;
  // output register
  logic [1:0]  o_kind;
  logic [3:0]  o_slot;
  logic [31:0] o_time, o_exp;
  logic        o_last, o_nv;
  logic [31:0] o_nc;

  wire [31:0] e_ref = rd_data[95:64];
  wire [31:0] e_exp = rd_data[63:32];
  wire        e_rep = rd_data[96];
  wire        e_on  = active[addr_q] & ~done_mask[addr_q];
  wire        e_hit = (e_exp - e_ref) <= (now - e_ref);
  wire [31:0] od    = now - e_exp;
  wire [31:0] gap   = e_hit ? 32'd0 : (e_exp - now);
  // one shared reciprocal multiplier: ms / 1000 first, then rate / 1000
  wire [31:0] div_in   = (dcnt == 2'd0) ? ms : tick_rate_hz;
  wire [63:0] div_prod = 64'(div_in) * 64'(maq_pkg::Recip1000);
  wire [31:0] div_q    = 32'(div_prod >> maq_pkg::RecipShift);
  wire slot_ok = {28'd0, slot_in} < NUM_SLOTS;

  assign s_axis_tready = (state == maq_pkg::ST_IDLE);
  assign m_axis_tvalid = (state == maq_pkg::ST_OUT);
  assign m_axis_tlast  = o_last;
  assign m_axis_tdata  = {1'b0, o_nc, o_nv, o_exp, o_time, o_slot, o_kind};

  always_comb begin
    state_next = state;
    rd_addr = cnt[SW-1:0];
    we = 1'b0;
    wr_addr = SW'(slot_in);
    wr_data = {mode == maq_pkg::MODE_ARM_REP, now,
               (mode == maq_pkg::MODE_ARM_REP) ? now + iv : expiry_in, iv};
    case (state)
      maq_pkg::ST_IDLE: begin
        rd_addr = '0;
        if (s_axis_tvalid) begin
          state_next = (s_axis_tdata[1:0] == maq_pkg::MODE_ARM_REP) ? maq_pkg::ST_CONV
                     : (s_axis_tdata[1:0] == maq_pkg::MODE_TICK) ? maq_pkg::ST_SCAN
                     : maq_pkg::ST_WRITE;
        end
      end
      maq_pkg::ST_CONV: if (dcnt == 2'd3) state_next = maq_pkg::ST_WRITE;
      maq_pkg::ST_WRITE: begin
        we = slot_ok && (mode != maq_pkg::MODE_CANCEL);
        rd_addr = '0;
        state_next = maq_pkg::ST_NEXT;
      end
      maq_pkg::ST_SCAN:
        if (cnt == CW'(NUM_SLOTS - 1)) state_next = maq_pkg::ST_SCAN_LAST;
      maq_pkg::ST_SCAN_LAST: state_next = maq_pkg::ST_EMIT;
      maq_pkg::ST_EMIT: begin
        rd_addr = '0;
        state_next = (best_found && nfired != 5'(maq_pkg::MaxResults))
                   ? maq_pkg::ST_UPDATE : maq_pkg::ST_NEXT;
      end
      maq_pkg::ST_UPDATE: begin
        we = best_rep;
        wr_addr = best_slot;
        wr_data = {1'b1, now, now + best_per, best_per};
        rd_addr = '0;
        state_next = maq_pkg::ST_SCAN;
      end
      maq_pkg::ST_NEXT:
        if (cnt == CW'(NUM_SLOTS - 1)) state_next = maq_pkg::ST_NEXT_LAST;
      maq_pkg::ST_NEXT_LAST: state_next = maq_pkg::ST_OUT;
      maq_pkg::ST_OUT:
        if (m_axis_tready && o_last) state_next = maq_pkg::ST_IDLE;
      default: state_next = maq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= maq_pkg::ST_IDLE;
      tick_rate_hz <= maq_pkg::RateReset;
      active <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) tick_rate_hz <= cfg_wdata;
      if (state == maq_pkg::ST_WRITE && slot_ok) begin
        active[SW'(slot_in)] <= (mode != maq_pkg::MODE_CANCEL);
      end
      if (state == maq_pkg::ST_UPDATE && !best_rep) active[best_slot] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    addr_q <= rd_addr;
    case (state)
      maq_pkg::ST_IDLE: begin
        mode      <= s_axis_tdata[1:0];
        slot_in   <= s_axis_tdata[5:2];
        now       <= s_axis_tdata[37:6];
        expiry_in <= s_axis_tdata[69:38];
        ms        <= s_axis_tdata[101:70];
        dcnt      <= '0;
        iv        <= '0;
        cnt       <= CW'(1);
        nfired    <= '0;
        done_mask <= '0;
        best_found <= 1'b0;
      end
      maq_pkg::ST_CONV: begin
        dcnt <= dcnt + 2'd1;
        case (dcnt)
          2'd0: quo <= div_q;
          2'd1: begin
            rem    <= ms - quo * maq_pkg::MsPerSec;
            rate_k <= div_q;
          end
          2'd2: iv <= quo * tick_rate_hz;
          default: iv <= iv + rem * rate_k;
        endcase
      end
      maq_pkg::ST_WRITE: begin
        cnt <= CW'(1);
        best_found <= 1'b0;
      end
      maq_pkg::ST_SCAN, maq_pkg::ST_SCAN_LAST: begin
        cnt <= cnt + CW'(1);
        if (e_on && e_hit && (!best_found || od > best_val)) begin
          best_found <= 1'b1;
          best_val   <= od;
          best_exp   <= e_exp;
          best_slot  <= addr_q;
          best_rep   <= e_rep;
          best_per   <= rd_data[31:0];
        end
      end
      maq_pkg::ST_EMIT: begin
        cnt <= CW'(1);
        if (best_found && nfired != 5'(maq_pkg::MaxResults)) begin
          // record the fire; results go out once next_compare is known
          fire_slot[nfired[3:0]] <= 4'(best_slot);
          fire_exp[nfired[3:0]]  <= best_exp;
          nfired <= nfired + 5'd1;
          done_mask[best_slot] <= 1'b1;
        end else begin
          best_found <= 1'b0;
        end
      end
      maq_pkg::ST_UPDATE: begin
        cnt <= CW'(1);
        best_found <= 1'b0;
      end
      maq_pkg::ST_NEXT, maq_pkg::ST_NEXT_LAST: begin
        cnt <= cnt + CW'(1);
        if (active[addr_q] && (!best_found || gap < best_val)) begin
          best_found <= 1'b1;
          best_val   <= gap;
          best_exp   <= e_exp;
        end
        if (state == maq_pkg::ST_NEXT_LAST) begin
          // first result of this input: first fire, idle tick or acknowledge
          eidx <= 4'd1;
          if (mode == maq_pkg::MODE_TICK && nfired != 5'd0) begin
            o_kind <= maq_pkg::KIND_FIRED;
            o_slot <= fire_slot[0];
            o_time <= now;
            o_exp  <= fire_exp[0];
            o_last <= (nfired == 5'd1);
          end else begin
            o_kind <= (mode == maq_pkg::MODE_TICK) ? maq_pkg::KIND_IDLE
                                                   : maq_pkg::KIND_ACK;
            o_slot <= '0;
            o_time <= '0;
            o_exp  <= '0;
            o_last <= 1'b1;
          end
        end
      end
      maq_pkg::ST_OUT: begin
        // advance to the next recorded fire once the current one is taken
        if (m_axis_tready && !o_last) begin
          o_slot <= fire_slot[eidx];
          o_exp  <= fire_exp[eidx];
          o_last <= ({1'b0, eidx} + 5'd1 == nfired);
          eidx   <= eidx + 4'd1;
        end
      end
      default: ;
    endcase
  end

  // next_compare is shared by every result of the input; fold in the last
  // entry, whose scan result lands in the same edge.
  logic [31:0] nc_final;
  logic        nv_final;
  always_comb begin
    nv_final = best_found;
    nc_final = best_found ? best_exp : 32'd0;
  end
  always_ff @(posedge clk) begin
    if (state == maq_pkg::ST_NEXT_LAST) begin
      o_nv <= nv_final || (active[addr_q]);
      o_nc <= (active[addr_q] && (!best_found || gap < best_val)) ? e_exp : nc_final;
    end
  end
endmodule

@@ src/maq_checker.sv @@
// ----------------------------------------------------------------------------
// maq_checker
// Port-level checks for the alarm queue.
// ----------------------------------------------------------------------------
module maq_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [103:0] m_axis_tdata,
  input logic         m_axis_tlast
);
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  a_fire_not_last_idle: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[1:0] == maq_pkg::KIND_IDLE |-> m_axis_tlast)
    else $error("idle tick not last");
  a_nv: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[70] |-> m_axis_tdata[102:71] == 32'd0)
    else $error("compare without pending");
endmodule

bind multiplexed_alarm_queue maq_checker u_maq_checker (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the multiplexed alarm queue: directed arm, cancel
// and tick sequences, then random alarm traffic under sender gaps, receiver
// stalls and a long output hold-off, checked against an in-bench predictor.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Slots = 16;

  // One predicted output transfer.
  typedef struct {
    maq_pkg::kind_t kind;
    logic [3:0]  fired_slot;
    logic [31:0] fire_time;
    logic [31:0] fired_expiry;
    logic        last;
    logic        next_valid;
    logic [31:0] next_compare;
  } alarm_result_t;

  logic         clk;
  logic         rst;
  logic         cfg_we;
  logic [31:0]  cfg_wdata;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata;   // mode, slot, now, expiry, period_ms, zero pad
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [103:0] m_axis_tdata;   // kind, fired_slot, fire_time, fired_expiry,
                                // next_valid, next_compare, zero pad
  logic         m_axis_tlast;

  // Predictor state: our own copy of the slot table and the rate register.
  logic [31:0] rate_hz;
  logic        alarm_on   [Slots];
  logic        alarm_rep  [Slots];
  logic [31:0] alarm_ref  [Slots];
  logic [31:0] alarm_exp  [Slots];
  logic [31:0] alarm_per  [Slots];

  alarm_result_t pending_results[$];

  int errors;
  int items_sent;
  int alarms_fired;
  int results_seen;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;
  logic [31:0] clock_now;   // running counter value for well-formed traffic

  multiplexed_alarm_queue #(.NUM_SLOTS(Slots)) u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #20ms;
    $display("timeout with %0d results still expected", pending_results.size());
    $display("*** FAILED ***");
    $finish;
  end

  // An alarm has expired once its distance from the reference is covered.
  function automatic logic alarm_due(int s, logic [31:0] now);
    logic [31:0] span;
    logic [31:0] gone;
    span = alarm_exp[s] - alarm_ref[s];
    gone = now - alarm_ref[s];
    return span <= gone;
  endfunction

  // Work out the transfers one input causes and queue them in order.
  function automatic void predict_alarms(maq_pkg::mode_t mode, logic [3:0] slot,
                                         logic [31:0] now, logic [31:0] exp_in,
                                         logic [31:0] ms);
    alarm_result_t batch[$];
    alarm_result_t r;
    logic          due[Slots];
    logic [31:0]   ticks;
    logic [31:0]   od;
    logic [31:0]   best;
    logic [31:0]   d;
    logic [31:0]   best_d;
    logic [31:0]   best_e;
    logic          found;
    int            pick;
    r = '{maq_pkg::KIND_ACK, 4'd0, 32'd0, 32'd0, 1'b0, 1'b0, 32'd0};
    if (mode == maq_pkg::MODE_ARM_ABS || mode == maq_pkg::MODE_ARM_REP) begin
      ticks = 32'd0;
      if (mode == maq_pkg::MODE_ARM_REP)
        ticks = (ms / maq_pkg::MsPerSec) * rate_hz +
                (ms % maq_pkg::MsPerSec) * (rate_hz / maq_pkg::MsPerSec);
      alarm_on[slot]  = 1'b1;
      alarm_rep[slot] = (mode == maq_pkg::MODE_ARM_REP);
      alarm_ref[slot] = now;
      alarm_exp[slot] = (mode == maq_pkg::MODE_ARM_REP) ? now + ticks : exp_in;
      alarm_per[slot] = ticks;
      batch.push_back(r);
    end else if (mode == maq_pkg::MODE_CANCEL) begin
      alarm_on[slot] = 1'b0;
      batch.push_back(r);
    end else begin
      for (int s = 0; s < Slots; s++) due[s] = alarm_on[s] && alarm_due(s, now);
      while (batch.size() < maq_pkg::MaxResults) begin
        found = 1'b0;
        pick  = 0;
        best  = 32'd0;
        for (int s = 0; s < Slots; s++) begin
          if (!due[s]) continue;
          od = now - alarm_exp[s];
          if (!found || od > best) begin
            found = 1'b1;
            best  = od;
            pick  = s;
          end
        end
        if (!found) break;
        due[pick] = 1'b0;
        r.kind         = maq_pkg::KIND_FIRED;
        r.fired_slot   = pick[3:0];
        r.fire_time    = now;
        r.fired_expiry = alarm_exp[pick];
        batch.push_back(r);
        if (alarm_rep[pick]) begin
          alarm_ref[pick] = now;
          alarm_exp[pick] = now + alarm_per[pick];
        end else begin
          alarm_on[pick] = 1'b0;
        end
      end
      if (batch.size() == 0) begin
        r.kind = maq_pkg::KIND_IDLE;
        batch.push_back(r);
      end
    end
    // Earliest pending expiry, overdue slots count as distance zero.
    found  = 1'b0;
    best_d = 32'd0;
    best_e = 32'd0;
    for (int s = 0; s < Slots; s++) begin
      if (!alarm_on[s]) continue;
      d = alarm_due(s, now) ? 32'd0 : alarm_exp[s] - now;
      if (!found || d < best_d) begin
        found  = 1'b1;
        best_d = d;
        best_e = alarm_exp[s];
      end
    end
    foreach (batch[k]) begin
      batch[k].last         = (k == batch.size() - 1);
      batch[k].next_valid   = found;
      batch[k].next_compare = found ? best_e : 32'd0;
      pending_results.push_back(batch[k]);
    end
  endfunction

  // Offer one input item; return at the falling edge after its transfer.
  task automatic send_item(maq_pkg::mode_t mode, logic [3:0] slot, logic [31:0] now,
                           logic [31:0] exp_in, logic [31:0] ms);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, ms, exp_in, now, slot, mode};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_alarms(mode, slot, now, exp_in, ms);
    items_sent++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every expected transfer has been taken.
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    @(negedge clk);
  endtask

  // Write the rate register while the block sits idle.
  task automatic write_rate(logic [31:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    rate_hz = value;
  endtask

  // Receiver: random stalls, or a counted hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check each output transfer against the oldest prediction.
  always @(posedge clk) begin
    alarm_result_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected transfer, tdata %h", m_axis_tdata);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (e.kind == maq_pkg::KIND_FIRED) alarms_fired++;
        if (m_axis_tdata[1:0] != e.kind) begin
          $error("kind: expected %0d actual %0d", e.kind, m_axis_tdata[1:0]);
          errors++;
        end
        if (m_axis_tdata[5:2] != e.fired_slot) begin
          $error("fired_slot: expected %0d actual %0d", e.fired_slot, m_axis_tdata[5:2]);
          errors++;
        end
        if (m_axis_tdata[37:6] != e.fire_time) begin
          $error("fire_time: expected %h actual %h", e.fire_time, m_axis_tdata[37:6]);
          errors++;
        end
        if (m_axis_tdata[69:38] != e.fired_expiry) begin
          $error("fired_expiry: expected %h actual %h", e.fired_expiry,
                 m_axis_tdata[69:38]);
          errors++;
        end
        if (m_axis_tlast != e.last) begin
          $error("last: expected %0d actual %0d", e.last, m_axis_tlast);
          errors++;
        end
        if (m_axis_tdata[70] != e.next_valid) begin
          $error("next_valid: expected %0d actual %0d", e.next_valid, m_axis_tdata[70]);
          errors++;
        end
        if (m_axis_tdata[102:71] != e.next_compare) begin
          $error("next_compare: expected %h actual %h", e.next_compare,
                 m_axis_tdata[102:71]);
          errors++;
        end
      end
    end
  end

  // One-shot arm, idle tick, firing tick, cancels, expiry equal to the reference.
  task automatic test_one_shot;
    send_item(maq_pkg::MODE_TICK, 4'd0, 32'd100, 32'd0, 32'd0);
    send_item(maq_pkg::MODE_ARM_ABS, 4'd0, 32'd100, 32'd105, 32'd0);
    send_item(maq_pkg::MODE_TICK, 4'd0, 32'd104, 32'd0, 32'd0);
    send_item(maq_pkg::MODE_TICK, 4'd0, 32'd105, 32'd0, 32'd0);
    send_item(maq_pkg::MODE_ARM_ABS, 4'd3, 32'd200, 32'd200, 32'd0);
    send_item(maq_pkg::MODE_ARM_ABS, 4'd4, 32'd200, 32'hFFFF_FFFF, 32'd0);
    send_item(maq_pkg::MODE_CANCEL, 4'd4, 32'd201, 32'd0, 32'd0);
    send_item(maq_pkg::MODE_CANCEL, 4'd9, 32'd201, 32'd0, 32'd0);
    send_item(maq_pkg::MODE_TICK, 4'd0, 32'd201, 32'd0, 32'd0);
  endtask

  // Repeating alarms with zero and nonzero periods; re-armed slots wait a tick.
  task automatic test_repeating;
    send_item(maq_pkg::MODE_ARM_REP, 4'd15, 32'd300, 32'd0, 32'd0);
    send_item(maq_pkg::MODE_TICK, 4'd0, 32'd300, 32'd0, 32'd0);
    send_item(maq_pkg::MODE_TICK, 4'd0, 32'd301, 32'd0, 32'd0);
    send_item(maq_pkg::MODE_CANCEL, 4'd15, 32'd302, 32'd0, 32'd0);
    send_item(maq_pkg::MODE_ARM_REP, 4'd7, 32'd400, 32'd0, 32'd1);
    send_item(maq_pkg::MODE_TICK, 4'd0, 32'd432, 32'd0, 32'd0);
    send_item(maq_pkg::MODE_TICK, 4'd0, 32'd500, 32'd0, 32'd0);
    send_item(maq_pkg::MODE_CANCEL, 4'd7, 32'd500, 32'd0, 32'd0);
  endtask

  // Every slot expires on one tick: tie order and a full burst.
  task automatic test_full_burst;
    for (int s = 0; s < Slots; s++)
      send_item(maq_pkg::MODE_ARM_ABS, s[3:0], 32'hFFFF_FFF0, (s < 8) ? 32'h5 : 32'h3,
                32'd0);
    send_item(maq_pkg::MODE_TICK, 4'd0, 32'h0000_0010, 32'd0, 32'd0);
  endtask

  // Rate extremes and interval conversion corners, wrap across zero.
  task automatic test_conversion;
    logic [31:0] rates[4];
    rates = '{32'd1000, 32'hFFFF_FFFF, 32'd44100, maq_pkg::RateReset};
    foreach (rates[i]) begin
      write_rate(rates[i]);
      send_item(maq_pkg::MODE_ARM_REP, 4'd1, 32'hFFFF_FF00, 32'd0, 32'hFFFF_FFFF);
      send_item(maq_pkg::MODE_ARM_REP, 4'd2, 32'hFFFF_FF00, 32'd0, 32'd999);
      send_item(maq_pkg::MODE_ARM_REP, 4'd3, 32'hFFFF_FF00, 32'd0, 32'd1000);
      send_item(maq_pkg::MODE_TICK, 4'd0, 32'h0000_0100, 32'd0, 32'd0);
      for (int s = 1; s < 4; s++)
        send_item(maq_pkg::MODE_CANCEL, s[3:0], 32'd0, 32'd0, 32'd0);
    end
  endtask

  // Well-formed alarm traffic around a running counter, with some noise.
  task automatic test_random_traffic(int n);
    int          pick;
    logic [3:0]  slot;
    logic [31:0] now;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      slot = 4'($urandom_range(15));
      now  = ($urandom_range(19) == 0) ? $urandom : clock_now;
      if (pick < 30)
        send_item(maq_pkg::MODE_ARM_ABS, slot, now,
                  ($urandom_range(9) == 0) ? $urandom : now + $urandom_range(300),
                  $urandom);
      else if (pick < 45)
        send_item(maq_pkg::MODE_ARM_REP, slot, now, $urandom,
                  ($urandom_range(9) == 0) ? $urandom : $urandom_range(20));
      else if (pick < 55)
        send_item(maq_pkg::MODE_CANCEL, slot, now, $urandom, $urandom);
      else begin
        clock_now = ($urandom_range(29) == 0) ? $urandom : clock_now + $urandom_range(200);
        send_item(maq_pkg::MODE_TICK, slot, clock_now, $urandom, $urandom);
      end
    end
  endtask

  // Hold the output off for a long stretch while items keep coming.
  task automatic test_backpressure;
    @(posedge clk);
    hold_left = 400;
    @(negedge clk);
    for (int s = 0; s < 6; s++)
      send_item(maq_pkg::MODE_ARM_ABS, s[3:0], clock_now, clock_now + s, 32'd0);
    clock_now = clock_now + 10;
    send_item(maq_pkg::MODE_TICK, 4'd0, clock_now, 32'd0, 32'd0);
    test_random_traffic(10);
  endtask

  initial begin
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_wdata      = 32'd0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    m_axis_tready  = 1'b0;
    errors         = 0;
    items_sent     = 0;
    alarms_fired   = 0;
    results_seen   = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    clock_now      = $urandom;
    rate_hz        = maq_pkg::RateReset;
    for (int s = 0; s < Slots; s++) begin
      alarm_on[s]  = 1'b0;
      alarm_rep[s] = 1'b0;
      alarm_ref[s] = 32'd0;
      alarm_exp[s] = 32'd0;
      alarm_per[s] = 32'd0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_one_shot();
    test_repeating();
    test_full_burst();
    test_conversion();

    // Random traffic across the idling phases, changing the rate in between.
    send_idle_pct = 0;  recv_stall_pct = 0;
    test_random_traffic(25);
    write_rate(32'd1000);
    send_idle_pct = 58; recv_stall_pct = 0;
    test_random_traffic(25);
    write_rate($urandom_range(32'hFFFF_FFFF, 1000));
    send_idle_pct = 0;  recv_stall_pct = 58;
    test_random_traffic(25);
    write_rate(32'hFFFF_FFFF);
    send_idle_pct = 26; recv_stall_pct = 26;
    test_random_traffic(25);
    send_idle_pct = 0;  recv_stall_pct = 0;
    test_backpressure();
    drain();

    $display("%0d items sent, %0d results checked, %0d alarms fired",
             items_sent, results_seen, alarms_fired);
    $display("covered arm, repeat, cancel, tick bursts, rate extremes, stalls");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/maq_pkg.sv
src/multiplexed_alarm_queue.sv
src/maq_checker.sv
tb/testbench.sv
